// ----- rtl/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator: field widths,
// controller states and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package ffha_pkg;

    // default arena size in 8-byte units
    localparam int unsigned HEAP_UNITS_DEF = 4096;

    // fixed request/result field widths
    localparam int unsigned SIZE_W = 15;
    localparam int unsigned ADDR_W = 15;
    // need = ceil((size + 8) / 8) is at most 4097
    localparam int unsigned NEED_W = 13;
    // unit index of a payload byte offset
    localparam int unsigned FIDX_W = ADDR_W - 3;

    // request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_A_CHK,
        S_A_CUR,
        S_A_NXT,
        S_A_SPLIT,
        S_A_TAKE,
        S_A_APP,
        S_F_CHK,
        S_F_WR
    } t_state;

    // header store read select
    typedef enum logic [1:0] {
        RD_NONE,
        RD_CUR,
        RD_NXT,
        RD_FREE
    } t_rd_sel;

    // header store write select
    typedef enum logic [2:0] {
        WR_NONE,
        WR_SPLIT,
        WR_TAKE,
        WR_MERGE,
        WR_APPEND,
        WR_FREE
    } t_wr_sel;

    // walk pointer advance select
    typedef enum logic [1:0] {
        ADV_NONE,
        ADV_RD,
        ADV_LEN,
        ADV_MRG
    } t_adv_sel;

    // current block length register select
    typedef enum logic [1:0] {
        LEN_HOLD,
        LEN_RD,
        LEN_MRG
    } t_len_sel;

    // result select
    typedef enum logic [1:0] {
        RES_NONE,
        RES_CUR,
        RES_TOP,
        RES_ZERO
    } t_res_sel;

    // controller to datapath
    typedef struct packed {
        logic     load;
        t_rd_sel  rd;
        t_wr_sel  wr;
        t_adv_sel adv;
        t_len_sel len;
        t_res_sel res;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic cur_lt_top;
        logic rd_len_zero;
        logic rd_used;
        logic rd_fit;
        logic nxt_lt_top;
        logic mrg_fit;
        logic split_need;
        logic app_fits;
        logic free_ok;
    } t_dp_sts;

endpackage

// ----- rtl/ffha_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffha_ctrl
// Controller for the allocator: sequences the first-fit header walk, merge
// probe, split and append for allocate requests, and the read-modify-write
// of a header for free requests.
// ----------------------------------------------------------------------------
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    i_req_type,
    input  t_dp_sts i_sts,
    output logic    busy,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (i_req_type == REQ_FREE) ? S_F_CHK : S_A_CHK;
                end
            end
            S_A_CHK: begin
                n_state = i_sts.cur_lt_top ? S_A_CUR : S_A_APP;
            end
            S_A_CUR: begin
                priority if (i_sts.rd_len_zero) begin
                    n_state = S_A_APP;
                end else if (i_sts.rd_used) begin
                    n_state = S_A_CHK;
                end else if (i_sts.rd_fit) begin
                    n_state = S_A_SPLIT;
                end else if (i_sts.nxt_lt_top) begin
                    n_state = S_A_NXT;
                end else begin
                    n_state = S_A_CHK;
                end
            end
            S_A_NXT: begin
                if (!i_sts.rd_used && i_sts.mrg_fit) begin
                    n_state = S_A_SPLIT;
                end else begin
                    n_state = S_A_CHK;
                end
            end
            S_A_SPLIT: n_state = S_A_TAKE;
            S_A_TAKE:  n_state = S_IDLE;
            S_A_APP:   n_state = S_IDLE;
            S_F_CHK:   n_state = i_sts.free_ok ? S_F_WR : S_IDLE;
            S_F_WR:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '{load: 1'b0, rd: RD_NONE, wr: WR_NONE, adv: ADV_NONE,
                       len: LEN_HOLD, res: RES_NONE};
        busy       = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
            end
            S_A_CHK: begin
                if (i_sts.cur_lt_top) begin
                    o_cmd.rd = RD_CUR;
                end
            end
            S_A_CUR: begin
                o_cmd.len = LEN_RD;
                if (!i_sts.rd_len_zero) begin
                    priority if (i_sts.rd_used) begin
                        o_cmd.adv = ADV_RD;
                    end else if (i_sts.rd_fit) begin
                        o_cmd.adv = ADV_NONE;
                    end else if (i_sts.nxt_lt_top) begin
                        o_cmd.rd = RD_NXT;
                    end else begin
                        o_cmd.adv = ADV_RD;
                    end
                end
            end
            S_A_NXT: begin
                // merge with a free successor, or step past the block
                if (!i_sts.rd_used) begin
                    if (i_sts.mrg_fit) begin
                        o_cmd.len = LEN_MRG;
                    end else begin
                        o_cmd.wr  = WR_MERGE;
                        o_cmd.adv = ADV_MRG;
                    end
                end else begin
                    o_cmd.adv = ADV_LEN;
                end
            end
            S_A_SPLIT: begin
                if (i_sts.split_need) begin
                    o_cmd.wr = WR_SPLIT;
                end
            end
            S_A_TAKE: begin
                o_cmd.wr  = WR_TAKE;
                o_cmd.res = RES_CUR;
            end
            S_A_APP: begin
                if (i_sts.app_fits) begin
                    o_cmd.wr = WR_APPEND;
                end
                o_cmd.res = RES_TOP;
            end
            S_F_CHK: begin
                if (i_sts.free_ok) begin
                    o_cmd.rd = RD_FREE;
                end else begin
                    o_cmd.res = RES_ZERO;
                end
            end
            S_F_WR: begin
                o_cmd.wr  = WR_FREE;
                o_cmd.res = RES_ZERO;
            end
            default: begin
                o_cmd.res = RES_NONE;
            end
        endcase
    end

endmodule

// ----- rtl/ffha_dp.sv -----
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath for the allocator: header store memory, walk pointer, block
// length, heap top, size rounding and the registered result.
// ----------------------------------------------------------------------------
module ffha_dp
    import ffha_pkg::*;
#(
    parameter int unsigned HEAP_UNITS = HEAP_UNITS_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SIZE_W-1:0] i_req_size,
    input  logic [ADDR_W-1:0] i_free_addr,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    output logic              o_done,
    output logic [ADDR_W-1:0] o_payload_addr,
    output logic              o_status
);

    // index, length and arithmetic widths
    localparam int unsigned AW = $clog2(HEAP_UNITS);
    localparam int unsigned LW = $clog2(HEAP_UNITS + 1);
    localparam int unsigned CW = ((LW > NEED_W) ? LW : NEED_W) + 1;
    localparam logic [CW-1:0] HEAP_X = CW'(HEAP_UNITS);

    // header store: {length, used}, no reset
    logic [LW:0] r_mem [HEAP_UNITS];
    logic [LW:0] r_rd;

    logic [NEED_W-1:0] r_need;
    logic [FIDX_W-1:0] r_fidx;
    logic              r_fnz;
    logic [CW-1:0]     r_cur;
    logic [CW-1:0]     r_len;
    logic [LW-1:0]     r_top;
    logic              r_done;
    logic [ADDR_W-1:0] r_payload;
    logic              r_status;

    logic [SIZE_W:0]   size_sum;
    logic [FIDX_W-1:0] fidx_in;
    logic [CW-1:0]     rd_len_x;
    logic [CW-1:0]     need_x;
    logic [CW-1:0]     top_x;
    logic [CW-1:0]     fidx_x;
    logic [CW-1:0]     nxt_rd;
    logic [CW-1:0]     mrg_len;
    logic [CW-1:0]     split_idx;
    logic [CW-1:0]     split_len;
    logic [CW-1:0]     app_sum;
    logic [CW-1:0]     pay_cur;
    logic [CW-1:0]     pay_top;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [LW:0]       wr_data;

    // size rounding and free index
    assign size_sum = {1'b0, i_req_size} + (SIZE_W + 1)'(15);
    assign fidx_in  = i_free_addr[ADDR_W-1:3] - FIDX_W'(1);

    // extended operands
    assign rd_len_x  = CW'(r_rd[LW:1]);
    assign need_x    = CW'(r_need);
    assign top_x     = CW'(r_top);
    assign fidx_x    = CW'(r_fidx);
    assign nxt_rd    = r_cur + rd_len_x;
    assign mrg_len   = r_len + rd_len_x;
    assign split_idx = r_cur + need_x;
    assign split_len = r_len - need_x;
    assign app_sum   = top_x + need_x;
    assign pay_cur   = r_cur + CW'(1);
    assign pay_top   = top_x + CW'(1);

    // status to controller
    always_comb begin
        o_sts.cur_lt_top  = (r_cur < top_x);
        o_sts.rd_len_zero = (rd_len_x == '0);
        o_sts.rd_used     = r_rd[0];
        o_sts.rd_fit      = (rd_len_x >= need_x);
        o_sts.nxt_lt_top  = (nxt_rd < top_x);
        o_sts.mrg_fit     = (mrg_len >= need_x);
        o_sts.split_need  = (r_len > need_x);
        o_sts.app_fits    = (app_sum <= HEAP_X);
        o_sts.free_ok     = r_fnz && (fidx_x < top_x) && (fidx_x < HEAP_X);
    end

    // read address select
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = r_cur[AW-1:0];
        unique case (i_cmd.rd)
            RD_NONE: rd_en   = 1'b0;
            RD_CUR:  rd_addr = r_cur[AW-1:0];
            RD_NXT:  rd_addr = nxt_rd[AW-1:0];
            RD_FREE: rd_addr = fidx_x[AW-1:0];
            default: rd_en   = 1'b0;
        endcase
    end

    // write address and data select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cur[AW-1:0];
        wr_data = {r_len[LW-1:0], 1'b0};
        unique case (i_cmd.wr)
            WR_NONE: wr_en = 1'b0;
            WR_SPLIT: begin
                wr_en   = (split_idx < HEAP_X);
                wr_addr = split_idx[AW-1:0];
                wr_data = {split_len[LW-1:0], 1'b0};
            end
            WR_TAKE: begin
                wr_en   = 1'b1;
                wr_addr = r_cur[AW-1:0];
                wr_data = {need_x[LW-1:0], 1'b1};
            end
            WR_MERGE: begin
                wr_en   = 1'b1;
                wr_addr = r_cur[AW-1:0];
                wr_data = {mrg_len[LW-1:0], 1'b0};
            end
            WR_APPEND: begin
                wr_en   = 1'b1;
                wr_addr = top_x[AW-1:0];
                wr_data = {need_x[LW-1:0], 1'b1};
            end
            WR_FREE: begin
                wr_en   = 1'b1;
                wr_addr = fidx_x[AW-1:0];
                wr_data = {r_rd[LW:1], 1'b0};
            end
            default: wr_en = 1'b0;
        endcase
    end

    // header store ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // request capture, walk pointer and block length
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_need <= size_sum[SIZE_W:3];
            r_fidx <= fidx_in;
            r_fnz  <= (i_free_addr[ADDR_W-1:3] != '0);
            r_cur  <= '0;
        end else begin
            unique case (i_cmd.adv)
                ADV_NONE: r_cur <= r_cur;
                ADV_RD:   r_cur <= nxt_rd;
                ADV_LEN:  r_cur <= r_cur + r_len;
                ADV_MRG:  r_cur <= r_cur + mrg_len;
                default:  r_cur <= r_cur;
            endcase
        end
        unique case (i_cmd.len)
            LEN_HOLD: r_len <= r_len;
            LEN_RD:   r_len <= rd_len_x;
            LEN_MRG:  r_len <= mrg_len;
            default:  r_len <= r_len;
        endcase
    end

    // heap top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
        end else if (i_cmd.wr == WR_APPEND) begin
            r_top <= app_sum[LW-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (i_cmd.res != RES_NONE);
        end
        unique case (i_cmd.res)
            RES_NONE: begin
                r_payload <= r_payload;
                r_status  <= r_status;
            end
            RES_CUR: begin
                r_payload <= {pay_cur[ADDR_W-4:0], 3'b000};
                r_status  <= 1'b0;
            end
            RES_TOP: begin
                if (o_sts.app_fits) begin
                    r_payload <= {pay_top[ADDR_W-4:0], 3'b000};
                    r_status  <= 1'b0;
                end else begin
                    r_payload <= '0;
                    r_status  <= 1'b1;
                end
            end
            RES_ZERO: begin
                r_payload <= '0;
                r_status  <= 1'b0;
            end
            default: begin
                r_payload <= r_payload;
                r_status  <= r_status;
            end
        endcase
    end

    assign o_done         = r_done;
    assign o_payload_addr = r_payload;
    assign o_status       = r_status;

endmodule

// ----- rtl/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator over an arena of 8-byte units with one header per
// block; allocate walks headers from the base, free clears a used bit.
// ----------------------------------------------------------------------------
//  channel   signals                                  handshake
//  request   i_req_type, i_req_size, i_free_addr     start & !busy
//  result    o_payload_addr, o_status                o_done, one cycle
//
//  allocate: each block stepped over is read in S_A_CHK and examined in S_A_CUR,
//  plus S_A_NXT when a too-small free block has a successor; a fit then passes
//  S_A_SPLIT and S_A_TAKE, and an append S_A_APP, where the result is registered.
//  free: S_F_CHK gives a zero result for an ignored free, else S_F_WR writes back.
//  reset is synchronous; the header store is not cleared. the receiver cannot
//  stall; a new request may start in the result cycle.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int unsigned HEAP_UNITS = HEAP_UNITS_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_req_type,
    input  logic [SIZE_W-1:0] i_req_size,
    input  logic [ADDR_W-1:0] i_free_addr,
    output logic              o_done,
    output logic [ADDR_W-1:0] o_payload_addr,
    output logic              o_status
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .busy       (busy),
        .o_cmd      (cmd)
    );

    // header store and arithmetic
    ffha_dp #(
        .HEAP_UNITS (HEAP_UNITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_size     (i_req_size),
        .i_free_addr    (i_free_addr),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_done         (o_done),
        .o_payload_addr (o_payload_addr),
        .o_status       (o_status)
    );

endmodule

// ----- bench/tb_first_fit_heap_allocator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Self-checking bench for the first-fit heap allocator. A shadow copy of the
// arena headers predicts every allocate and free result; a directed opener
// walks the split, merge, append and arena-full corners, then random
// allocate/free traffic runs with random request gaps.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
    import ffha_pkg::*;

    localparam int HEAP_UNITS  = HEAP_UNITS_DEF;
    localparam int UNIT_BYTES  = 8;
    localparam int N_RANDOM    = 600;
    // worst case: every allocate walks the whole arena, plus the longest request gap,
    // for every request, then tripled
    localparam int CYCLE_LIMIT = 25_000_000;

    typedef struct {
        logic              kind;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] faddr;
    } t_heap_req;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic              status;
    } t_heap_res;

    typedef struct {
        int idx;
        int size;
    } t_live_blk;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_req_type = REQ_ALLOC;
    logic [SIZE_W-1:0] i_req_size = '0;
    logic [ADDR_W-1:0] i_free_addr = '0;
    logic              o_done;
    logic [ADDR_W-1:0] o_payload_addr;
    logic              o_status;

    // shadow arena: header per unit plus a written flag
    bit [12:0] blk_len     [HEAP_UNITS];
    bit        blk_used    [HEAP_UNITS];
    bit        blk_written [HEAP_UNITS];
    int        heap_top = 0;

    t_heap_req pending_reqs[$];
    t_heap_res expected_results[$];
    t_live_blk live_blocks[$];

    int n_queued = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int err_cnt = 0;
    int n_alloc_ok = 0;
    int n_alloc_full = 0;
    int n_free = 0;
    int cycle_cnt = 0;

    first_fit_heap_allocator #(
        .HEAP_UNITS(HEAP_UNITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_req_size    (i_req_size),
        .i_free_addr   (i_free_addr),
        .o_done        (o_done),
        .o_payload_addr(o_payload_addr),
        .o_status      (o_status)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_cnt++;
    endtask

    function automatic void hdr_set(input int idx, input int len, input bit used);
        if (idx < HEAP_UNITS) begin
            blk_len[idx]     = len[12:0];
            blk_used[idx]    = used;
            blk_written[idx] = 1'b1;
        end
    endfunction

    // mark a free block used, leaving any surplus as a free remainder
    function automatic void claim_block(input int idx, input int need);
        int len;
        len = int'(blk_len[idx]);
        if (len > need)
            hdr_set(idx + need, len - need, 1'b0);
        hdr_set(idx, need, 1'b1);
    endfunction

    // first-fit walk with a single merge attempt per free block
    function automatic int first_fit(input int need);
        int cur;
        int len;
        int nxt;
        cur = 0;
        while (cur < heap_top) begin
            len = int'(blk_len[cur]);
            if (len == 0)
                break;
            if (!blk_used[cur]) begin
                if (len >= need) begin
                    claim_block(cur, need);
                    return cur;
                end
                nxt = cur + len;
                if (nxt < heap_top && !blk_used[nxt]) begin
                    len += int'(blk_len[nxt]);
                    hdr_set(cur, len, 1'b0);
                    if (len >= need) begin
                        claim_block(cur, need);
                        return cur;
                    end
                end
            end
            cur += len;
        end
        return -1;
    endfunction

    // apply one request to the shadow arena and return the result it gives
    function automatic t_heap_res predict_request(input t_heap_req req);
        t_heap_res res;
        int need;
        int hit;
        int base;
        int pay;
        int idx;
        t_live_blk blk;
        res.addr   = '0;
        res.status = 1'b0;
        if (req.kind == REQ_ALLOC) begin
            need = (int'(req.size) + 2 * UNIT_BYTES - 1) / UNIT_BYTES;
            hit  = first_fit(need);
            base = -1;
            if (hit >= 0) begin
                base = hit;
            end else if (heap_top + need <= HEAP_UNITS) begin
                hdr_set(heap_top, need, 1'b1);
                base = heap_top;
                heap_top += need;
            end
            if (base >= 0) begin
                pay      = (base + 1) * UNIT_BYTES;
                res.addr = pay[ADDR_W-1:0];
                n_alloc_ok++;
                // the last unit has no representable payload offset to free
                if (base < HEAP_UNITS - 1) begin
                    blk.idx  = base;
                    blk.size = int'(req.size);
                    live_blocks.push_back(blk);
                end
            end else begin
                res.status = 1'b1;
                n_alloc_full++;
            end
        end else begin
            n_free++;
            idx = int'(req.faddr) / UNIT_BYTES - 1;
            if (idx >= 0 && idx < heap_top)
                blk_used[idx] = 1'b0;
        end
        return res;
    endfunction

    task automatic queue_alloc(input int size);
        t_heap_req req;
        req.kind  = REQ_ALLOC;
        req.size  = size[SIZE_W-1:0];
        req.faddr = ADDR_W'($urandom);
        pending_reqs.push_back(req);
        n_queued++;
    endtask

    task automatic queue_free(input int faddr);
        t_heap_req req;
        req.kind  = REQ_FREE;
        req.size  = SIZE_W'($urandom);
        req.faddr = faddr[ADDR_W-1:0];
        pending_reqs.push_back(req);
        n_queued++;
    endtask

    // request driver with random gaps and gap-free bursts
    always @(posedge i_clk) begin : req_driver
        t_heap_req cur_req;
        t_heap_res pred;
        bit        fire;
        int        gap;
        int        gap_left;
        int        burst_left;
        int        r;
        if (!i_rst_n) begin
            start      <= 1'b0;
            gap_left   = 0;
            burst_left = 0;
        end else begin
            fire = start && !busy;
            if (fire) begin
                pred = predict_request(cur_req);
                expected_results.push_back(pred);
                n_accepted++;
                // pick the gap before the next request
                r = $urandom_range(99);
                if (burst_left > 0) begin
                    burst_left--;
                    gap = 0;
                end else if (r < 3) begin
                    burst_left = $urandom_range(60, 20);
                    gap = 0;
                end else if (r < 60) begin
                    gap = 0;
                end else if (r < 92) begin
                    gap = $urandom_range(3, 1);
                end else begin
                    gap = $urandom_range(40, 8);
                end
            end else begin
                gap = gap_left;
            end
            // hold a waiting request, otherwise load the next one
            if (!start || fire) begin
                if (gap == 0 && pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    start       <= 1'b1;
                    i_req_type  <= cur_req.kind;
                    i_req_size  <= cur_req.size;
                    i_free_addr <= cur_req.faddr;
                    gap_left = 0;
                end else begin
                    start <= 1'b0;
                    gap_left = (gap > 0) ? gap - 1 : 0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : res_monitor
        t_heap_res want;
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing outstanding: addr %0d status %0b",
                                          o_payload_addr, o_status));
            end else begin
                want = expected_results.pop_front();
                if (o_payload_addr !== want.addr)
                    report_mismatch($sformatf("result %0d payload_addr %0d, want %0d",
                                              n_checked, o_payload_addr, want.addr));
                if (o_status !== want.status)
                    report_mismatch($sformatf("result %0d status %0b, want %0b",
                                              n_checked, o_status, want.status));
                n_checked++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin : stimulus
        int        r;
        int        k;
        int        idx;
        int        hi;
        int        lo;
        int        tries;
        int        recent_size;
        int        faddr;
        bit        found;
        t_live_blk blk;

        recent_size = -1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners from an empty arena
        queue_alloc(0);          // header-only block at the base
        queue_alloc(8);
        queue_free(32767);       // header above the heap top, ignored
        queue_free(16);
        queue_alloc(16);         // free block too small, successor is the top
        queue_alloc(24);         // free block too small, successor used
        queue_free(32);
        queue_alloc(32);         // merge with free successor, exact fit
        queue_free(32);          // stale header inside a block
        queue_alloc(32672);      // fill up to the last unit
        queue_alloc(0);          // last unit, payload offset wraps to zero
        queue_alloc(0);          // arena full
        queue_alloc(32767);      // larger than the arena
        queue_free(88);
        queue_alloc(8);          // split of a large free block
        queue_free(13);          // unaligned offset
        queue_free(5);           // below the base
        queue_free(0);
        queue_alloc(0);          // exact fit at the base
        queue_alloc(100);

        // random traffic, each request built from the settled shadow state
        for (int n = 0; n < N_RANDOM; n++) begin
            while (n_accepted != n_queued)
                @(posedge i_clk);
            if ($urandom_range(99) < 55 || live_blocks.size() == 0) begin
                r = $urandom_range(99);
                if (r < 15 && recent_size >= 0)
                    queue_alloc(recent_size);
                else if (r < 45)
                    queue_alloc($urandom_range(63, 0));
                else if (r < 82)
                    queue_alloc($urandom_range(1023, 64));
                else if (r < 95)
                    queue_alloc($urandom_range(8191, 1024));
                else
                    queue_alloc($urandom_range(32767, 8192));
            end else begin
                r = $urandom_range(99);
                faddr = $urandom_range(7, 0);
                if (r < 65) begin
                    // release a block handed out earlier
                    k   = $urandom_range(live_blocks.size() - 1, 0);
                    blk = live_blocks[k];
                    live_blocks.delete(k);
                    recent_size = blk.size;
                    faddr = (blk.idx + 1) * UNIT_BYTES;
                    if ($urandom_range(9) == 0)
                        faddr += $urandom_range(7, 1);
                end else if (r < 80) begin
                    // any written header below the top: double or inner free
                    found = 1'b0;
                    if (heap_top > 0) begin
                        hi = (heap_top - 1 < HEAP_UNITS - 2) ? heap_top - 1 : HEAP_UNITS - 2;
                        for (tries = 0; tries < 20 && !found; tries++) begin
                            idx = $urandom_range(hi, 0);
                            found = blk_written[idx];
                        end
                    end
                    if (found)
                        faddr = (idx + 1) * UNIT_BYTES + $urandom_range(7, 0);
                end else if (r >= 90 && heap_top <= HEAP_UNITS - 2) begin
                    // header at or above the top
                    lo = (heap_top + 1) * UNIT_BYTES;
                    faddr = $urandom_range(32767, lo);
                end
                queue_free(faddr);
            end
        end

        // drain, then watch for stray results
        while (n_accepted != n_queued || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("ran %0d requests: %0d allocations granted, %0d refused for space, %0d frees",
                 n_accepted, n_alloc_ok, n_alloc_full, n_free);
        $display("%0d results compared, %0d mismatches, heap top at unit %0d",
                 n_checked, err_cnt, heap_top);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
